// ----- design/setx_pkg.sv -----
// ----------------------------------------------------------------------------
// setx_pkg
// Shared types, constants and decode helpers for the sprite tile expander.
// ----------------------------------------------------------------------------
package setx_pkg;

    // layer masks per priority, and the mask for the top colours
    localparam logic [15:0] MASK_PRIO0 = 16'hff00;
    localparam logic [15:0] MASK_PRIO1 = 16'hfff0;
    localparam logic [15:0] MASK_PRIO2 = 16'hfffc;
    localparam logic [15:0] MASK_PRIO3 = 16'hfffe;
    localparam logic [15:0] MASK_TOP   = 16'h0000;

    // colours at and above this value are drawn over every layer
    localparam logic [5:0] COLOR_TOP   = 6'h38;

    // vertical origin of the sprite y coordinate
    localparam logic [7:0] Y_ORIGIN    = 8'd240;

    // horizontal offset applied to the x position
    localparam logic [9:0] X_BIAS      = 10'd15;

    // quadrant index of the final tile of a 2x2 sprite
    localparam logic [1:0] QUAD_LAST   = 2'd3;

    // decoded sprite entry, held while its tiles go out
    typedef struct packed {
        logic [15:0] code;      // low two bits already cleared for 2x2
        logic [5:0]  palette;
        logic        flip_x;
        logic        flip_y;
        logic        single;
        logic [8:0]  xpos;
        logic [7:0]  ypos;      // already mapped to (240 - y) mod 256
        logic [15:0] mask;
    } t_entry;

    // one tile draw command
    typedef struct packed {
        logic [15:0] tile_code;
        logic [5:0]  palette;
        logic        flip_x;
        logic        flip_y;
        logic [9:0]  screen_x;
        logic [8:0]  screen_y;
        logic [15:0] layer_mask;
        logic        last_tile;
    } t_tile;

    // priority to layer mask
    function automatic logic [15:0] prio_mask(input logic [1:0] prio);
        logic [15:0] m;
        case (prio)
            2'd0:    m = MASK_PRIO0;
            2'd1:    m = MASK_PRIO1;
            2'd2:    m = MASK_PRIO2;
            2'd3:    m = MASK_PRIO3;
            default: m = MASK_PRIO0;
        endcase
        return m;
    endfunction

endpackage

// ----- design/setx_tile_gen.sv -----
// ----------------------------------------------------------------------------
// setx_tile_gen
// Builds one tile draw command from a decoded entry and a quadrant index.
// ----------------------------------------------------------------------------
module setx_tile_gen (
    input  setx_pkg::t_entry i_entry,
    input  logic [1:0]       i_quad,
    output setx_pkg::t_tile  o_tile
);

    logic row;
    logic col;
    logic qc;
    logic qr;

    // screen order: index bit 1 is the row, bit 0 the column
    assign row = i_quad[1] & ~i_entry.single;
    assign col = i_quad[0] & ~i_entry.single;

    // quadrant picked in flip order
    assign qc = col ^ i_entry.flip_x;
    assign qr = row ^ i_entry.flip_y;

    always_comb begin
        o_tile.palette    = i_entry.palette;
        o_tile.flip_x     = i_entry.flip_x;
        o_tile.flip_y     = i_entry.flip_y;
        o_tile.layer_mask = i_entry.mask;

        if (i_entry.single) begin
            o_tile.tile_code = i_entry.code;
            o_tile.last_tile = 1'b1;
        end else begin
            // low bits are zero, so the offset add is a plain concatenation
            o_tile.tile_code = {i_entry.code[15:2], qc, qr};
            o_tile.last_tile = (i_quad == setx_pkg::QUAD_LAST);
        end

        o_tile.screen_x = {1'b0, i_entry.xpos} - setx_pkg::X_BIAS
                          + {6'd0, col, 3'd0};
        o_tile.screen_y = {1'b0, i_entry.ypos} + {5'd0, row, 3'd0};
    end

endmodule

// ----- design/sprite_entry_tile_expander.sv -----
// ----------------------------------------------------------------------------
// sprite_entry_tile_expander
// Expands one sprite table entry into one or four 8x8 tile draw commands.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A single-tile sprite
// produces one command, a 2x2 sprite four, one per clock in screen order, each
// shown for exactly one cycle with o_valid high; the receiver cannot stall.
// A request is registered into the held entry, and each command is registered
// again on its way out. One output port paces the block, and
// a new request is taken in the same cycle the previous sprite's last tile is
// generated, so requests can follow each other with no gap.
module sprite_entry_tile_expander (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_attr_y_word,
    input  logic [15:0] i_x_color_word,
    input  logic [15:0] i_tile_number,
    output logic        o_valid,
    output logic [15:0] o_tile_code,
    output logic [5:0]  o_palette,
    output logic        o_flip_x,
    output logic        o_flip_y,
    output logic [9:0]  o_screen_x,
    output logic [8:0]  o_screen_y,
    output logic [15:0] o_layer_mask,
    output logic        o_last_tile
);

    setx_pkg::t_entry r_entry;
    setx_pkg::t_entry n_entry;
    logic             r_active;
    logic             n_active;
    logic [1:0]       r_quad;
    logic [1:0]       n_quad;
    logic             r_valid;
    setx_pkg::t_tile  r_tile;
    setx_pkg::t_tile  tile;
    logic             accept;
    logic [5:0]       color;

    // tile for the current quadrant
    setx_tile_gen u_tile_gen (
        .i_entry (r_entry),
        .i_quad  (r_quad),
        .o_tile  (tile)
    );

    // free once the last tile of the held entry is being generated
    assign busy   = r_active & ~tile.last_tile;
    assign accept = start & ~busy;

    // entry decode
    assign color = i_x_color_word[14:9];
    always_comb begin
        n_entry.palette = color;
        n_entry.flip_x  = i_attr_y_word[14];
        n_entry.flip_y  = i_attr_y_word[15];
        n_entry.single  = i_attr_y_word[11];
        n_entry.xpos    = i_x_color_word[8:0];
        n_entry.ypos    = setx_pkg::Y_ORIGIN - i_attr_y_word[7:0];
        n_entry.code    = i_attr_y_word[11] ? i_tile_number
                                            : {i_tile_number[15:2], 2'b00};
        n_entry.mask    = (color >= setx_pkg::COLOR_TOP)
                          ? setx_pkg::MASK_TOP
                          : setx_pkg::prio_mask(i_attr_y_word[13:12]);
    end

    // sequencing of the quadrants
    always_comb begin
        n_active = r_active;
        n_quad   = r_quad;
        if (r_active) begin
            if (tile.last_tile) begin
                n_active = 1'b0;
            end else begin
                n_quad = r_quad + 2'd1;
            end
        end
        if (accept) begin
            n_active = 1'b1;
            n_quad   = 2'd0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_quad   <= 2'd0;
            r_valid  <= 1'b0;
        end else begin
            r_active <= n_active;
            r_quad   <= n_quad;
            r_valid  <= r_active;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry <= n_entry;
        end
        if (r_active) begin
            r_tile <= tile;
        end
    end

    assign o_valid      = r_valid;
    assign o_tile_code  = r_tile.tile_code;
    assign o_palette    = r_tile.palette;
    assign o_flip_x     = r_tile.flip_x;
    assign o_flip_y     = r_tile.flip_y;
    assign o_screen_x   = r_tile.screen_x;
    assign o_screen_y   = r_tile.screen_y;
    assign o_layer_mask = r_tile.layer_mask;
    assign o_last_tile  = r_tile.last_tile;

endmodule
